[hdl/etcs_pkg.sv]
// Types and constants shared by the EEPROM transfer command sequencer.
package etcs_pkg;

  localparam int ADDR_W = 17;
  localparam int CNT_W  = 18;

  // operation codes on the request channel
  localparam logic OP_BEGIN   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_START  = 2'd0;
  localparam logic [1:0] CFG_LENM1  = 2'd1;
  localparam logic [1:0] CFG_FILL   = 2'd2;
  localparam logic [1:0] CFG_DIR    = 2'd3;

  // byte engine command register codes
  localparam logic [7:0] CMD_NONE     = 8'h00;
  localparam logic [7:0] CMD_START_WR = 8'h91;
  localparam logic [7:0] CMD_WR       = 8'h11;
  localparam logic [7:0] CMD_WR_STOP  = 8'h51;
  localparam logic [7:0] CMD_RD_ACK   = 8'h21;
  localparam logic [7:0] CMD_RD_STOP  = 8'h69;

  // device control bytes
  localparam logic [7:0] CTRL_EVEN = 8'hA0;
  localparam logic [7:0] CTRL_ODD  = 8'hA8;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_CTRL  = 7'b0000010,
    PH_AHI   = 7'b0000100,
    PH_ALO   = 7'b0001000,
    PH_RCTRL = 7'b0010000,
    PH_WDATA = 7'b0100000,
    PH_RDATA = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len_m1;
    logic [7:0]        fill;
    logic              dir;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [ADDR_W-1:0] cur_addr;
    logic [CNT_W-1:0]  remaining;
    logic [ADDR_W-1:0] seg_left;
    logic              rd_pend;
    logic [ADDR_W-1:0] pend_addr;
    logic              xfer_dir;
    logic [7:0]        xfer_fill;
  } seq_state_t;

  typedef struct packed {
    logic [7:0]        tx_byte;
    logic [7:0]        command;
    logic [7:0]        read_data;
    logic [ADDR_W-1:0] read_address;
    logic              read_valid;
    logic              done_res;
  } seq_result_t;

endpackage

[hdl/etcs_step.sv]
// Next-state and result logic for one sequencer request.
module etcs_step import etcs_pkg::*; #(
  parameter int PAGE_BYTES   = 128,
  parameter int BANK_BYTES   = 65536,
  parameter int DEVICE_BYTES = 131072
) (
  input  seq_state_t  st,
  input  cfg_t        cfg,
  input  logic        op,
  input  logic [7:0]  rx_byte,
  output seq_state_t  st_nxt,
  output seq_result_t res
);

  // page and bank sizes are powers of two
  localparam int BANK_LG = $clog2(BANK_BYTES);
  localparam logic [ADDR_W-1:0] BANK_MASK = ADDR_W'(BANK_BYTES - 1);
  localparam logic [ADDR_W-1:0] BANK_SIZE = ADDR_W'(BANK_BYTES);
  localparam logic [8:0]        PAGE_MASK = 9'(PAGE_BYTES - 1);
  localparam logic [8:0]        PAGE_SIZE = 9'(PAGE_BYTES);
  localparam logic [CNT_W-1:0]  DEV_SIZE  = CNT_W'(DEVICE_BYTES);

  logic [ADDR_W-1:0] off;
  logic [7:0]        ctrl;
  logic [ADDR_W-1:0] bank_room;
  logic [8:0]        page_room;
  logic [CNT_W-1:0]  seg_a;
  logic [CNT_W-1:0]  seg_b;
  logic [CNT_W-1:0]  n_req;
  logic [CNT_W-1:0]  room;
  logic [CNT_W-1:0]  rem_dec;
  logic [ADDR_W-1:0] seg_dec;
  logic              last;

  always_comb begin
    off       = st.cur_addr & BANK_MASK;
    ctrl      = st.cur_addr[BANK_LG] ? CTRL_ODD : CTRL_EVEN;
    bank_room = BANK_SIZE - off;
    page_room = PAGE_SIZE - (9'(st.cur_addr) & PAGE_MASK);
    seg_a     = (st.remaining < {1'b0, bank_room}) ? st.remaining : {1'b0, bank_room};
    seg_b     = (!st.xfer_dir && ({9'd0, page_room} < seg_a)) ? {9'd0, page_room} : seg_a;
    n_req     = {1'b0, cfg.len_m1} + CNT_W'(1);
    room      = DEV_SIZE - {1'b0, cfg.start};
    rem_dec   = st.remaining - CNT_W'(st.remaining != '0);
    seg_dec   = st.seg_left - ADDR_W'(st.seg_left != '0);
    last      = (seg_dec == '0);

    st_nxt = st;
    res    = '0;

    // a byte read by the previous command goes out with whatever comes next
    if (st.rd_pend) begin
      res.read_valid   = 1'b1;
      res.read_data    = rx_byte;
      res.read_address = st.pend_addr;
      st_nxt.rd_pend   = 1'b0;
    end

    if (op == OP_BEGIN) begin
      st_nxt.xfer_dir  = cfg.dir;
      st_nxt.xfer_fill = cfg.fill;
      st_nxt.cur_addr  = cfg.start;
      st_nxt.seg_left  = '0;
      if ({1'b0, cfg.start} >= DEV_SIZE) begin
        st_nxt.remaining = '0;
        st_nxt.phase     = PH_IDLE;
        res.done_res     = 1'b1;
      end else begin
        st_nxt.remaining = (n_req > room) ? room : n_req;
        st_nxt.phase     = PH_AHI;
        res.tx_byte      = cfg.start[BANK_LG] ? CTRL_ODD : CTRL_EVEN;
        res.command      = CMD_START_WR;
      end
    end else begin
      case (st.phase)
        PH_IDLE: begin
          st_nxt.phase = PH_IDLE;
        end
        PH_CTRL: begin
          res.tx_byte  = ctrl;
          res.command  = CMD_START_WR;
          st_nxt.phase = PH_AHI;
        end
        PH_AHI: begin
          // segment length is settled here, before any data byte needs it
          res.tx_byte     = 8'(off >> 8);
          res.command     = CMD_WR;
          st_nxt.seg_left = ADDR_W'(seg_b);
          st_nxt.phase    = PH_ALO;
        end
        PH_ALO: begin
          res.tx_byte  = off[7:0];
          res.command  = CMD_WR;
          st_nxt.phase = st.xfer_dir ? PH_RCTRL : PH_WDATA;
        end
        PH_RCTRL: begin
          res.tx_byte  = ctrl | 8'h01;
          res.command  = CMD_START_WR;
          st_nxt.phase = PH_RDATA;
        end
        PH_WDATA, PH_RDATA: begin
          if (st.phase == PH_RDATA) begin
            st_nxt.rd_pend   = 1'b1;
            st_nxt.pend_addr = st.cur_addr;
            res.command      = last ? CMD_RD_STOP : CMD_RD_ACK;
          end else begin
            res.tx_byte = st.xfer_fill;
            res.command = last ? CMD_WR_STOP : CMD_WR;
          end
          st_nxt.seg_left  = seg_dec;
          st_nxt.remaining = rem_dec;
          st_nxt.cur_addr  = st.cur_addr + ADDR_W'(1);
          if (last) begin
            if (rem_dec == '0) begin
              res.done_res = 1'b1;
              st_nxt.phase = PH_IDLE;
            end else begin
              st_nxt.phase = PH_CTRL;
            end
          end
        end
        default: begin
          st_nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/eeprom_transfer_command_sequencer_core.sv]
// Top level of the EEPROM transfer command sequencer.
//
// Feeds an I2C byte engine for a two-bank EEPROM. Each request on the in_
// channel is a begin (in_tuser = 0, transfer taken from the cfg registers)
// or an advance (in_tuser = 1, previous command finished; in_tdata holds the
// byte the engine received). Every request yields exactly one result on the
// out_ channel: transmit byte, command byte, and any byte returned by the
// previous read command with its address (out_tuser marks it valid).
// out_tlast marks the final command of the whole transfer, or a begin whose start lies beyond the device.
// A request is registered at the input, worked through by the single
// next-state pass and lands in the output register, which drives
// out_tvalid; one request per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the output register holds and an empty input
// register still takes one more request; once it is full, in_tready drops.
// Reset (rst_n low at a clock edge) empties both registers, returns the
// sequencer to idle and clears the cfg registers. Write cfg only while idle.
module eeprom_transfer_command_sequencer_core import etcs_pkg::*; #(
  parameter int PAGE_BYTES   = 128,
  parameter int BANK_BYTES   = 65536,
  parameter int DEVICE_BYTES = 131072
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [ADDR_W-1:0] cfg_wdata,
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] rx_byte
  input  logic              in_tuser,   // [0] operation
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // [7:0] tx_byte, [15:8] command,
                                        // [23:16] read_data, [40:24] read_address
  output logic              out_tuser,  // [0] read_valid
  output logic              out_tlast   // done_res
);

  cfg_t        cfg_r;
  seq_state_t  st_r, st_nxt;
  seq_result_t res_nxt, res_r;
  logic        in_vld_r;
  logic        in_op_r;
  logic [7:0]  in_rx_r;
  logic        out_vld_r;
  logic        adv;
  logic        fire;

  assign adv       = !out_vld_r || out_tready;
  assign fire      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_START: cfg_r.start  <= cfg_wdata;
        CFG_LENM1: cfg_r.len_m1 <= cfg_wdata;
        CFG_FILL:  cfg_r.fill   <= cfg_wdata[7:0];
        CFG_DIR:   cfg_r.dir    <= cfg_wdata[0];
        default:   cfg_r        <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r <= in_tuser;
      in_rx_r <= in_tdata;
    end
  end

  etcs_step #(
    .PAGE_BYTES   (PAGE_BYTES),
    .BANK_BYTES   (BANK_BYTES),
    .DEVICE_BYTES (DEVICE_BYTES)
  ) u_step (
    .st      (st_r),
    .cfg     (cfg_r),
    .op      (in_op_r),
    .rx_byte (in_rx_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, cur_addr: '0, remaining: '0, seg_left: '0,
                rd_pend: 1'b0, pend_addr: '0, xfer_dir: 1'b0, xfer_fill: '0};
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, res_r.read_address, res_r.read_data,
                       res_r.command, res_r.tx_byte};
  assign out_tuser  = res_r.read_valid;
  assign out_tlast  = res_r.done_res;

endmodule
